// ----- hdl/grid_circle_collision_assert.svh -----
// ----------------------------------------------------------------------------
// Grid circle collision assertion macros
// Shared property forms for the collision block checks.
// ----------------------------------------------------------------------------
`ifndef GRID_CIRCLE_COLLISION_ASSERT_SVH
`define GRID_CIRCLE_COLLISION_ASSERT_SVH

// Same-cycle implication, quiet while reset is low.
`define GCC_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is low.
`define GCC_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid circle collision package
// Word types, state codes and arithmetic widths shared by the block.
// ----------------------------------------------------------------------------
package gcc_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_WALK    = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [7:0]  cell_col;
        logic [7:0]  cell_row;
        logic        rock_in;
        logic [13:0] pos_x;
        logic [13:0] pos_y;
        logic [7:0]  circle_radius;
    } cmd_t;

    typedef struct packed {
        logic        is_free;
        logic [13:0] new_x;
        logic [13:0] new_y;
        logic        rock_out;
    } rsp_t;

    localparam int CRD_W  = 22;
    localparam int CIDX_W = 12;
    localparam int MUL_W  = 18;
    localparam int DVD_W  = 16;
    localparam int DVS_W  = 8;
    localparam int POS_W  = 14;
    localparam logic [POS_W-1:0] POS_MAX = 14'h3FFF;

    typedef logic signed [CRD_W-1:0]   crd_t;
    typedef logic signed [CIDX_W-1:0]  cidx_t;
    typedef logic signed [MUL_W-1:0]   mop_t;
    typedef logic signed [2*MUL_W-1:0] mprod_t;
    typedef logic signed [2*MUL_W:0]   acc_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RDCELL,
        S_RDWAIT,
        S_WINIT,
        S_READ,
        S_SQX,
        S_SQY,
        S_SQR,
        S_CMP,
        S_SQRT,
        S_MULX,
        S_DSTX,
        S_DIVX,
        S_MULY,
        S_DSTY,
        S_DIVY,
        S_NEXT,
        S_WDONE,
        S_CLAMP,
        S_OUT
    } seq_state_t;

endpackage

// ----- hdl/gcc_occ_mem.sv -----
// ----------------------------------------------------------------------------
// Occupancy memory
// One bit per grid cell, one write port and one registered read port.
// ----------------------------------------------------------------------------
module gcc_occ_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/gcc_isqrt.sv -----
// ----------------------------------------------------------------------------
// Integer square root
// Floored root of a 16-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gcc_isqrt import gcc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] value,
    output logic             done,
    output logic [DVS_W-1:0] root
);

    logic [DVD_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] res_reg, res_next;
    logic [DVD_W-1:0] bit_reg, bit_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVD_W:0]   trial;
    logic             ge;

    always_comb
    begin
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        ge        = {1'b0, rem_reg} >= trial;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = value;
            res_next  = '0;
            bit_next  = {2'b01, {(DVD_W-2){1'b0}}};
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = DVD_W'({1'b0, rem_reg} - trial);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == DVD_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[DVS_W-1:0];

endmodule

// ----- hdl/gcc_divider.sv -----
// ----------------------------------------------------------------------------
// Unsigned divider
// Restoring division of a 16-bit magnitude by an 8-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module gcc_divider import gcc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dq_reg, dq_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic             ge;

    always_comb
    begin
        shifted   = {rem_reg, dq_reg[DVD_W-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DVS_W'(shifted - {1'b0, dvs_reg}) : DVS_W'(shifted);
            dq_next  = {dq_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ----- hdl/grid_circle_collision.sv -----
// A write stores one cell bit and a read returns one; a walkable query tests the covered cells
// in turn up to the first rock cell that the circle overlaps. A resolve that fails it then visits
// up to 9 neighbor cells, a pushing cell taking a root and two divisions.
// One word is in work at a time; the shared multiplier, root and divider units set the rate.
// After reset a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells empties the grid.
// Commands are stalled during that pass and whenever a word is in work.
// ----------------------------------------------------------------------------
// Grid circle collision
// Occupancy grid with cell access, walkable test and circle push-out.
// ----------------------------------------------------------------------------
`include "grid_circle_collision_assert.svh"

module grid_circle_collision import gcc_pkg::*; #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 128,
    parameter int CELL_UNITS  = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SH    = $clog2(CELL_UNITS);
    localparam int EXT_X = GRID_WIDTH * CELL_UNITS;
    localparam int EXT_Y = GRID_HEIGHT * CELL_UNITS;
    localparam int HI_X  = (GRID_WIDTH - 1) * CELL_UNITS;
    localparam int HI_Y  = (GRID_HEIGHT - 1) * CELL_UNITS;

    seq_state_t state_reg, state_next;

    cmd_t    cmd_reg, cmd_next;
    crd_t    x_reg, x_next, y_reg, y_next;
    cidx_t   col_reg, col_next, row_reg, row_next;
    cidx_t   col_lo_reg, col_lo_next, col_hi_reg, col_hi_next, row_hi_reg, row_hi_next;
    mop_t    dx_reg, dx_next, dy_reg, dy_next;
    acc_t    acc_reg, acc_next;
    mprod_t  mul_reg;
    logic    free_reg, free_next, rock_reg, rock_next;
    logic    ingrid_reg, ingrid_next, resolve_reg, resolve_next, neg_reg, neg_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic    rsp_valid_reg;
    rsp_t    rsp_reg;

    mop_t    mul_a, mul_b, ov;
    crd_t    r_crd, lo_x, hi_x, lo_y, hi_y, cell_x, cell_y, clamp_lo, clamp_x, clamp_y;
    crd_t    q_signed;
    logic    accept, load_rsp, cur_in_grid, cmd_in_grid, bound_fail, test_cell;
    logic    less, last_cell;
    logic    mem_we, mem_wdata, mem_rdata;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic    sq_start, sq_done, div_start, div_done;
    logic [DVS_W-1:0] sq_root;
    logic [DVD_W-1:0] div_q, div_dvd;
    mprod_t  mul_abs;
    rsp_t    rsp_word;

    function automatic crd_t nearest(crd_t lo, crd_t p);
        crd_t hi;
        crd_t m;
        hi = lo + crd_t'(CELL_UNITS);
        m  = (p < hi) ? p : hi;
        return (m > lo) ? m : lo;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(crd_t v);
        logic [POS_W-1:0] s;
        if (v < 0)
        begin
            s = '0;
        end
        else if (v > crd_t'(POS_MAX))
        begin
            s = POS_MAX;
        end
        else
        begin
            s = v[POS_W-1:0];
        end
        return s;
    endfunction

    gcc_occ_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    gcc_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (acc_reg[DVD_W-1:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    gcc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (sq_root),
        .done     (div_done),
        .quotient (div_q)
    );

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = state_reg != S_IDLE;
    assign load_rsp  = (state_reg == S_OUT) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        r_crd       = crd_t'(cmd_reg.circle_radius);
        lo_x        = x_reg - r_crd;
        hi_x        = x_reg + r_crd;
        lo_y        = y_reg - r_crd;
        hi_y        = y_reg + r_crd;
        bound_fail  = (lo_x < 0) || (hi_x >= crd_t'(EXT_X)) ||
                      (lo_y < 0) || (hi_y >= crd_t'(EXT_Y));
        cur_in_grid = (col_reg >= 0) && (col_reg < cidx_t'(GRID_WIDTH)) &&
                      (row_reg >= 0) && (row_reg < cidx_t'(GRID_HEIGHT));
        cmd_in_grid = (11'(cmd_reg.cell_col) < 11'(GRID_WIDTH)) &&
                      (11'(cmd_reg.cell_row) < 11'(GRID_HEIGHT));
        cell_x      = crd_t'(col_reg) <<< SH;
        cell_y      = crd_t'(row_reg) <<< SH;
        test_cell   = resolve_reg ? (ingrid_reg && mem_rdata) : (!ingrid_reg || mem_rdata);
        less        = acc_reg < acc_t'(mul_reg);
        last_cell   = (col_reg == col_hi_reg) && (row_reg == row_hi_reg);
        ov          = mop_t'(cmd_reg.circle_radius) - mop_t'(sq_root);
        mul_abs     = mul_reg[2*MUL_W-1] ? -mul_reg : mul_reg;
        div_dvd     = mul_abs[DVD_W-1:0];
        q_signed    = neg_reg ? -crd_t'(div_q) : crd_t'(div_q);
        clamp_lo    = r_crd + crd_t'(CELL_UNITS);
        clamp_x     = (x_reg < clamp_lo) ? clamp_lo : x_reg;
        clamp_x     = (clamp_x > crd_t'(HI_X) - r_crd) ? crd_t'(HI_X) - r_crd : clamp_x;
        clamp_y     = (y_reg < clamp_lo) ? clamp_lo : y_reg;
        clamp_y     = (clamp_y > crd_t'(HI_Y) - r_crd) ? crd_t'(HI_Y) - r_crd : clamp_y;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(32'(cmd_reg.cell_row) * GRID_WIDTH + 32'(cmd_reg.cell_col));
        mem_wdata = cmd_reg.rock_in;
        mem_raddr = AW'(32'($unsigned(row_reg)) * GRID_WIDTH + 32'($unsigned(col_reg)));
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = 1'b0;
        end
        else if (state_reg == S_DISPATCH && cmd_reg.operation == OP_WRITE && cmd_in_grid)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_SQY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            S_SQR:
            begin
                mul_a = mop_t'(cmd_reg.circle_radius);
                mul_b = mop_t'(cmd_reg.circle_radius);
            end
            S_MULX:
            begin
                mul_a = dx_reg;
                mul_b = ov;
            end
            S_MULY:
            begin
                mul_a = dy_reg;
                mul_b = ov;
            end
            default:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
        endcase
    end

    assign sq_start  = (state_reg == S_CMP) && resolve_reg && less && (acc_reg != '0);
    assign div_start = (state_reg == S_DSTX) || (state_reg == S_DSTY);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg.operation)
                    OP_WRITE: state_next = S_IDLE;
                    OP_READ:  state_next = S_RDCELL;
                    default:  state_next = S_WINIT;
                endcase
            end
            S_RDCELL: state_next = S_RDWAIT;
            S_RDWAIT: state_next = S_OUT;
            S_WINIT:  state_next = bound_fail ? S_WDONE : S_READ;
            S_READ:   state_next = S_SQX;
            S_SQX:    state_next = test_cell ? S_SQY : S_NEXT;
            S_SQY:    state_next = S_SQR;
            S_SQR:    state_next = S_CMP;
            S_CMP:
            begin
                if (!resolve_reg)
                begin
                    state_next = less ? S_WDONE : S_NEXT;
                end
                else
                begin
                    state_next = sq_start ? S_SQRT : S_NEXT;
                end
            end
            S_SQRT:
            begin
                if (sq_done)
                begin
                    state_next = S_MULX;
                end
            end
            S_MULX:   state_next = S_DSTX;
            S_DSTX:   state_next = S_DIVX;
            S_DIVX:
            begin
                if (div_done)
                begin
                    state_next = S_MULY;
                end
            end
            S_MULY:   state_next = S_DSTY;
            S_DSTY:   state_next = S_DIVY;
            S_DIVY:
            begin
                if (div_done)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (last_cell)
                begin
                    state_next = resolve_reg ? S_CLAMP : S_WDONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_WDONE:
            begin
                if (cmd_reg.operation == OP_RESOLVE && !free_reg)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_CLAMP:  state_next = S_OUT;
            S_OUT:
            begin
                if (load_rsp)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next     = cmd_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        col_lo_next  = col_lo_reg;
        col_hi_next  = col_hi_reg;
        row_hi_next  = row_hi_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        acc_next     = acc_reg;
        free_next    = free_reg;
        rock_next    = rock_reg;
        ingrid_next  = ingrid_reg;
        resolve_next = resolve_reg;
        neg_next     = neg_reg;
        clr_next     = clr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = cmd;
                    x_next       = crd_t'(cmd.pos_x);
                    y_next       = crd_t'(cmd.pos_y);
                    resolve_next = 1'b0;
                end
            end
            S_DISPATCH:
            begin
                col_next = cidx_t'(cmd_reg.cell_col);
                row_next = cidx_t'(cmd_reg.cell_row);
            end
            S_RDCELL:
            begin
                ingrid_next = cur_in_grid;
            end
            S_RDWAIT:
            begin
                rock_next = !ingrid_reg || mem_rdata;
            end
            S_WINIT:
            begin
                free_next   = !bound_fail;
                col_lo_next = cidx_t'(lo_x >>> SH);
                col_next    = cidx_t'(lo_x >>> SH);
                col_hi_next = cidx_t'(hi_x >>> SH);
                row_next    = cidx_t'(lo_y >>> SH);
                row_hi_next = cidx_t'(hi_y >>> SH);
            end
            S_READ:
            begin
                ingrid_next = cur_in_grid;
                dx_next     = mop_t'(x_reg - nearest(cell_x, x_reg));
                dy_next     = mop_t'(y_reg - nearest(cell_y, y_reg));
            end
            S_SQY:
            begin
                acc_next = acc_t'(mul_reg);
            end
            S_SQR:
            begin
                acc_next = acc_reg + acc_t'(mul_reg);
            end
            S_CMP:
            begin
                if (!resolve_reg && less)
                begin
                    free_next = 1'b0;
                end
            end
            S_DSTX, S_DSTY:
            begin
                neg_next = mul_reg[2*MUL_W-1];
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    x_next = x_reg + q_signed;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    y_next = y_reg + q_signed;
                end
            end
            S_NEXT:
            begin
                if (col_reg == col_hi_reg)
                begin
                    col_next = col_lo_reg;
                    if (!last_cell)
                    begin
                        row_next = row_reg + cidx_t'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + cidx_t'(1);
                end
            end
            S_WDONE:
            begin
                if (cmd_reg.operation == OP_RESOLVE && !free_reg)
                begin
                    resolve_next = 1'b1;
                    col_lo_next  = cidx_t'(x_reg >>> SH) - cidx_t'(1);
                    col_next     = cidx_t'(x_reg >>> SH) - cidx_t'(1);
                    col_hi_next  = cidx_t'(x_reg >>> SH) + cidx_t'(1);
                    row_next     = cidx_t'(y_reg >>> SH) - cidx_t'(1);
                    row_hi_next  = cidx_t'(y_reg >>> SH) + cidx_t'(1);
                end
            end
            S_CLAMP:
            begin
                x_next = clamp_x;
                y_next = clamp_y;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_word          = '0;
        rsp_word.is_free  = (cmd_reg.operation == OP_WALK) && free_reg;
        rsp_word.rock_out = (cmd_reg.operation == OP_READ) && rock_reg;
        if (cmd_reg.operation == OP_RESOLVE)
        begin
            rsp_word.new_x = sat_pos(x_reg);
            rsp_word.new_y = sat_pos(y_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            resolve_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            resolve_reg <= resolve_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        col_lo_reg <= col_lo_next;
        col_hi_reg <= col_hi_next;
        row_hi_reg <= row_hi_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        acc_reg    <= acc_next;
        free_reg   <= free_next;
        rock_reg   <= rock_next;
        ingrid_reg <= ingrid_next;
        neg_reg    <= neg_next;
        mul_reg    <= mul_a * mul_b;
        if (load_rsp)
        begin
            rsp_reg <= rsp_word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `GCC_ASSERT_IMP(a_clear_stalls, state_reg == S_CLEAR, cmd_stall, "Command taken during clear.")
    `GCC_ASSERT_IMP(a_load_room, load_rsp, !rsp_valid_reg || !rsp_stall, "Result word overwritten.")
    `GCC_ASSERT_NXT(a_write_silent, accept && cmd.operation == OP_WRITE, !load_rsp && !rsp_valid_reg || rsp_valid_reg, "Write produced a result.")
    `GCC_ASSERT_IMP(a_unit_order, div_start, !sq_start, "Root and divider started together.")

endmodule
